// ===== design/tgapu_pkg.sv =====
// Package for the TGA pixel unpacker.
// Holds the action, status, register index and image type codes and the depth constants.
// No dependencies.
`default_nettype none

package tgapu_pkg;

    typedef enum logic [1:0] {
        ACT_PIXEL   = 2'd0,
        ACT_PALETTE = 2'd1,
        ACT_RESTART = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_PIXEL        = 2'd0,
        ST_NO_DATA      = 2'd1,
        ST_BAD_DEPTH    = 2'd2,
        ST_UNKNOWN_TYPE = 2'd3
    } t_status;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_TYPE   = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_DEPTH  = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 4'd3;

    localparam logic [7:0] TYPE_NO_DATA    = 8'd0;
    localparam logic [7:0] TYPE_COLORMAP   = 8'd1;
    localparam logic [7:0] TYPE_TRUECOLOR  = 8'd2;

    localparam logic [7:0] DEPTH_16 = 8'd16;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

`default_nettype wire

// ===== design/tga_pixel_unpacker_top.sv =====
// Top level of the TGA pixel unpacker: byte decode, pixel count and output stage.
// Depends on tgapu_pkg and tgapu_palette.
//
// Usage: the input channel (i_in_valid / o_in_ready) carries one transaction per
// byte of uncompressed pixel data, per palette write or per image restart. The
// output channel (o_out_valid / i_out_ready) carries one decoded pixel each time
// the bytes of a pixel are complete, or one error transaction on the first data
// byte while the image type or depth is invalid. The configuration port writes
// image type, depth, width and height; the user does so only while the block is idle (not enforced).
// The decode stage registers a result and its palette read when the transaction that
// caused it is accepted; the result then moves on into the output register.
// Throughput: one input transaction per cycle, sustained while the receiver takes
// every result as it is presented.
// Reset clears the registers, the pixel count and the byte collector; palette
// contents are undefined until written. When the receiver stalls, one result
// waits in the output register and one more in the decode stage, after which
// o_in_ready drops until the output register is taken.
`default_nettype none

module tga_pixel_unpacker_top
    import tgapu_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_action,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic [7:0]            i_palette_index,
    input  wire logic [23:0]           i_palette_entry,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [1:0]                 o_status,
    output logic [7:0]                 o_red,
    output logic [7:0]                 o_green,
    output logic [7:0]                 o_blue,
    output logic [7:0]                 o_alpha,
    output logic                       o_has_alpha,
    output logic                       o_last_pixel
);

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);

    logic [7:0]  r_image_type;
    logic [7:0]  r_pixel_depth;
    logic [15:0] r_image_width;
    logic [15:0] r_image_height;

    logic [31:0] r_pixel_count, n_pixel_count;
    logic [1:0]  r_phase, n_phase;
    logic [23:0] r_collect, n_collect;
    logic        r_err_done, n_err_done;

    logic        r_s1_valid;
    t_status     r_s1_status;
    logic [7:0]  r_s1_red, r_s1_green, r_s1_blue, r_s1_alpha;
    logic        r_s1_has_alpha, r_s1_last, r_s1_pal, r_s1_pal_ok;

    logic        r_out_valid;
    t_status     r_out_status;
    logic [7:0]  r_out_red, r_out_green, r_out_blue, r_out_alpha;
    logic        r_out_has_alpha, r_out_last;

    logic        w_in_acc, w_s1_adv;
    t_action     w_action;
    t_status     w_err;
    logic [2:0]  w_bpp;
    logic [31:0] w_total;
    logic        w_res, w_pal_re, w_pal_we, w_pal_ok, w_wr_ok;
    t_status     w_status;
    logic [7:0]  w_red, w_green, w_blue, w_alpha;
    logic        w_has_alpha, w_last;
    logic [15:0] w_c16;
    logic [23:0] w_rdata;

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_action   = t_action'(i_action);
    assign w_total    = {16'd0, r_image_width} * {16'd0, r_image_height};
    assign w_c16      = {i_data_byte, r_collect[7:0]};
    assign w_pal_ok   = {1'b0, i_data_byte} < 9'(PALETTE_ENTRIES);
    assign w_wr_ok    = {1'b0, i_palette_index} < 9'(PALETTE_ENTRIES);

    always_comb begin
        w_err = ST_PIXEL;
        w_bpp = 3'd1;
        if (r_image_type == TYPE_NO_DATA) begin
            w_err = ST_NO_DATA;
        end else if (r_image_type == TYPE_COLORMAP) begin
            w_bpp = 3'd1;
        end else if (r_image_type == TYPE_TRUECOLOR) begin
            if (r_pixel_depth == DEPTH_16) begin
                w_bpp = 3'd2;
            end else if (r_pixel_depth == DEPTH_24) begin
                w_bpp = 3'd3;
            end else if (r_pixel_depth == DEPTH_32) begin
                w_bpp = 3'd4;
            end else begin
                w_err = ST_BAD_DEPTH;
            end
        end else begin
            w_err = ST_UNKNOWN_TYPE;
        end
    end

    always_comb begin
        n_pixel_count = r_pixel_count;
        n_phase       = r_phase;
        n_collect     = r_collect;
        n_err_done    = r_err_done;
        w_res         = 1'b0;
        w_pal_re      = 1'b0;
        w_pal_we      = 1'b0;
        w_status      = ST_PIXEL;
        w_red         = 8'd0;
        w_green       = 8'd0;
        w_blue        = 8'd0;
        w_alpha       = 8'd0;
        w_has_alpha   = 1'b0;
        w_last        = 1'b0;
        if (w_in_acc) begin
            unique case (w_action)
                ACT_PALETTE: begin
                    w_pal_we = w_wr_ok;
                end
                ACT_RESTART: begin
                    n_pixel_count = 32'd0;
                    n_phase       = 2'd0;
                    n_collect     = 24'd0;
                    n_err_done    = 1'b0;
                end
                ACT_PIXEL: begin
                    if (w_err != ST_PIXEL) begin
                        if (!r_err_done) begin
                            n_err_done = 1'b1;
                            w_res      = 1'b1;
                            w_status   = w_err;
                        end
                    end else if (r_pixel_count < w_total) begin
                        if ({1'b0, r_phase} + 3'd1 < w_bpp) begin
                            unique case (r_phase)
                                2'd0: n_collect[7:0]   = i_data_byte;
                                2'd1: n_collect[15:8]  = r_collect[15:8] | i_data_byte;
                                2'd2: n_collect[23:16] = r_collect[23:16] | i_data_byte;
                                default: n_collect = r_collect;
                            endcase
                            n_phase = r_phase + 2'd1;
                        end else begin
                            w_res         = 1'b1;
                            w_alpha       = ALPHA_OPAQUE;
                            n_phase       = 2'd0;
                            n_collect     = 24'd0;
                            n_pixel_count = r_pixel_count + 32'd1;
                            w_last        = (r_pixel_count + 32'd1) == w_total;
                            unique case (w_bpp)
                                3'd1: begin
                                    w_pal_re = 1'b1;
                                end
                                3'd2: begin
                                    w_red   = {w_c16[14:10], 3'b000};
                                    w_green = {w_c16[9:5], 3'b000};
                                    w_blue  = {w_c16[4:0], 3'b000};
                                end
                                3'd3: begin
                                    w_blue  = r_collect[7:0];
                                    w_green = r_collect[15:8];
                                    w_red   = i_data_byte;
                                end
                                default: begin
                                    w_blue      = r_collect[7:0];
                                    w_green     = r_collect[15:8];
                                    w_red       = r_collect[23:16];
                                    w_alpha     = i_data_byte;
                                    w_has_alpha = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    w_res = 1'b0;
                end
            endcase
        end
    end

    tgapu_palette #(
        .ENTRIES(PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_pal_we),
        .i_waddr (i_palette_index[ADDR_W-1:0]),
        .i_wdata (i_palette_entry),
        .i_re    (w_pal_re),
        .i_raddr (i_data_byte[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_type   <= 8'd0;
            r_pixel_depth  <= 8'd0;
            r_image_width  <= 16'd0;
            r_image_height <= 16'd0;
        end else if (i_cfg_we) begin
            priority if (i_cfg_addr == REG_IMAGE_TYPE) begin
                r_image_type <= i_cfg_wdata[7:0];
            end else if (i_cfg_addr == REG_PIXEL_DEPTH) begin
                r_pixel_depth <= i_cfg_wdata[7:0];
            end else if (i_cfg_addr == REG_IMAGE_WIDTH) begin
                r_image_width <= i_cfg_wdata;
            end else if (i_cfg_addr == REG_IMAGE_HEIGHT) begin
                r_image_height <= i_cfg_wdata;
            end else begin
                r_image_type <= r_image_type;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= 32'd0;
            r_phase       <= 2'd0;
            r_collect     <= 24'd0;
            r_err_done    <= 1'b0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_pixel_count <= n_pixel_count;
            r_phase       <= n_phase;
            r_collect     <= n_collect;
            r_err_done    <= n_err_done;
            if (w_in_acc) begin
                r_s1_valid <= w_res;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_res) begin
            r_s1_status    <= w_status;
            r_s1_red       <= w_red;
            r_s1_green     <= w_green;
            r_s1_blue      <= w_blue;
            r_s1_alpha     <= w_alpha;
            r_s1_has_alpha <= w_has_alpha;
            r_s1_last      <= w_last;
            r_s1_pal       <= w_pal_re;
            r_s1_pal_ok    <= w_pal_ok;
        end
        if (w_s1_adv) begin
            r_out_status    <= r_s1_status;
            r_out_alpha     <= r_s1_alpha;
            r_out_has_alpha <= r_s1_has_alpha;
            r_out_last      <= r_s1_last;
            if (r_s1_pal) begin
                r_out_red   <= r_s1_pal_ok ? w_rdata[23:16] : 8'd0;
                r_out_green <= r_s1_pal_ok ? w_rdata[15:8] : 8'd0;
                r_out_blue  <= r_s1_pal_ok ? w_rdata[7:0] : 8'd0;
            end else begin
                r_out_red   <= r_s1_red;
                r_out_green <= r_s1_green;
                r_out_blue  <= r_s1_blue;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_red        = r_out_red;
    assign o_green      = r_out_green;
    assign o_blue       = r_out_blue;
    assign o_alpha      = r_out_alpha;
    assign o_has_alpha  = r_out_has_alpha;
    assign o_last_pixel = r_out_last;

`ifndef NO_ASSERTIONS
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_adv |=> r_s1_valid)
        else $error("Decode stage lost a pending transaction.");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("Input accepted while both result stages are stalled.");

    a_error_is_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_PIXEL |-> o_red == 8'd0 && o_green == 8'd0
            && o_blue == 8'd0 && o_alpha == 8'd0 && !o_has_alpha && !o_last_pixel)
        else $error("Error transaction carries pixel data.");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_red) && $stable(o_green) && $stable(o_blue)
            && $stable(o_alpha) && $stable(o_has_alpha) && $stable(o_last_pixel))
        else $error("Result transaction changed while the receiver stalled.");
`endif

endmodule

`default_nettype wire

// ===== design/tgapu_palette.sv =====
// Palette memory of the TGA pixel unpacker: one write port, one read port.
// The read data is registered and holds until the next read. No dependencies.
`default_nettype none

module tgapu_palette #(
    parameter int ENTRIES = 256,
    localparam int ADDR_W = $clog2(ENTRIES)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [23:0]       i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [23:0]       o_rdata
);

    logic [23:0] r_mem [ENTRIES];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== tb/tgapu_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the TGA pixel unpacker testbench: a decode predictor and the queue
// of expected pixel and error transactions. Depends on tgapu_pkg.
package tgapu_tb_pkg;
    import tgapu_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        t_status    status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       has_alpha;
        logic       last_pixel;
    } t_pixel_result;

    class pixel_scoreboard;
        logic [23:0]   palette [256];
        logic [31:0]   pixel_count;
        int            byte_phase;
        logic [23:0]   collected;
        bit            error_sent;
        logic [7:0]    img_type;
        logic [7:0]    img_depth;
        logic [15:0]   img_width;
        logic [15:0]   img_height;
        t_pixel_result expected_pixels[$];
        int            failures;
        int            pixels_seen;
        int            ends_seen;
        int            errors_seen;

        function new();
            clear_image();
            img_type = '0;
            img_depth = '0;
            img_width = '0;
            img_height = '0;
            failures = 0;
            pixels_seen = 0;
            ends_seen = 0;
            errors_seen = 0;
        endfunction

        function void clear_image();
            pixel_count = '0;
            byte_phase = 0;
            collected = '0;
            error_sent = 1'b0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] val);
            case (addr)
                REG_IMAGE_TYPE: img_type = val[7:0];
                REG_PIXEL_DEPTH: img_depth = val[7:0];
                REG_IMAGE_WIDTH: img_width = val;
                REG_IMAGE_HEIGHT: img_height = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Returns 1 when the transaction changed the decoder state or produced a result.
        function bit absorb_input(logic [1:0] act, logic [7:0] data, logic [7:0] pidx,
                                  logic [23:0] pent);
            t_pixel_result res;
            t_status       fault;
            logic [31:0]   total;
            logic [15:0]   word16;
            logic [23:0]   entry;
            int            bpp;
            if (act == ACT_PALETTE) begin
                palette[pidx] = pent;
                return 1'b1;
            end
            if (act == ACT_RESTART) begin
                clear_image();
                return 1'b1;
            end
            if (act != ACT_PIXEL)
                return 1'b0;

            fault = ST_PIXEL;
            bpp = 1;
            if (img_type == TYPE_NO_DATA) begin
                fault = ST_NO_DATA;
            end else if (img_type == TYPE_TRUECOLOR) begin
                case (img_depth)
                    DEPTH_16: bpp = 2;
                    DEPTH_24: bpp = 3;
                    DEPTH_32: bpp = 4;
                    default: fault = ST_BAD_DEPTH;
                endcase
            end else if (img_type != TYPE_COLORMAP) begin
                fault = ST_UNKNOWN_TYPE;
            end

            if (fault != ST_PIXEL) begin
                if (error_sent)
                    return 1'b0;
                error_sent = 1'b1;
                res = '0;
                res.status = fault;
                expected_pixels.push_back(res);
                return 1'b1;
            end

            total = 32'(img_width) * 32'(img_height);
            if (pixel_count >= total)
                return 1'b0;
            if (byte_phase + 1 < bpp) begin
                collected = collected | (24'(data) << (8 * byte_phase));
                byte_phase++;
                return 1'b1;
            end

            res = '0;
            res.status = ST_PIXEL;
            res.alpha = ALPHA_OPAQUE;
            case (bpp)
                1: begin
                    entry = palette[data];
                    res.blue = entry[7:0];
                    res.green = entry[15:8];
                    res.red = entry[23:16];
                end
                2: begin
                    word16 = {data, collected[7:0]};
                    res.red = {word16[14:10], 3'b000};
                    res.green = {word16[9:5], 3'b000};
                    res.blue = {word16[4:0], 3'b000};
                end
                3: begin
                    res.blue = collected[7:0];
                    res.green = collected[15:8];
                    res.red = data;
                end
                default: begin
                    res.blue = collected[7:0];
                    res.green = collected[15:8];
                    res.red = collected[23:16];
                    res.alpha = data;
                    res.has_alpha = 1'b1;
                end
            endcase
            byte_phase = 0;
            collected = '0;
            pixel_count++;
            res.last_pixel = (pixel_count == total);
            expected_pixels.push_back(res);
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_pixel(logic [1:0] status, logic [7:0] red, logic [7:0] green,
                                  logic [7:0] blue, logic [7:0] alpha, logic has_alpha,
                                  logic last_pixel);
            t_pixel_result want;
            if (expected_pixels.size() == 0) begin
                $error("Unexpected result transaction: status %0h, rgba %h %h %h %h",
                       status, red, green, blue, alpha);
                failures++;
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("status", want.status, status);
            compare_field("red", want.red, red);
            compare_field("green", want.green, green);
            compare_field("blue", want.blue, blue);
            compare_field("alpha", want.alpha, alpha);
            compare_field("has_alpha", want.has_alpha, has_alpha);
            compare_field("last_pixel", want.last_pixel, last_pixel);
            if (want.status != ST_PIXEL) begin
                errors_seen++;
            end else begin
                pixels_seen++;
                if (want.last_pixel)
                    ends_seen++;
            end
        endfunction
    endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the TGA pixel unpacker testbench: clock, reset, transaction drivers and stimulus.
// Depends on tgapu_pkg, tgapu_tb_pkg and tga_pixel_unpacker_top.
module tb_top;
    import tgapu_pkg::*;
    import tgapu_tb_pkg::*;

    localparam int PALETTE_SIZE  = 256;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 900;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_action = ACT_PIXEL;
    logic [7:0]            i_data_byte = '0;
    logic [7:0]            i_palette_index = '0;
    logic [23:0]           i_palette_entry = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [1:0]            o_status;
    logic [7:0]            o_red;
    logic [7:0]            o_green;
    logic [7:0]            o_blue;
    logic [7:0]            o_alpha;
    logic                  o_has_alpha;
    logic                  o_last_pixel;

    pixel_scoreboard sb;
    bit              tx_choppy = 1'b1;
    bit              rx_choppy = 1'b1;
    int              rx_hold = 0;
    int              idle_cycles = 0;
    int              items_sent = 0;
    int              settings_used = 0;

    always #5 i_clk = ~i_clk;

    tga_pixel_unpacker_top #(.PALETTE_ENTRIES(PALETTE_SIZE)) dut (.*);

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 2))
            0: return 16'd0;
            1: return 16'd1;
            default: return 16'hFFFF;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (rx_hold > 0)
            rx_hold = rx_hold - 1;
        else if (rx_choppy && $urandom_range(0, 3) == 0)
            rx_hold = pick_gap();
        i_out_ready <= (rx_hold == 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_pixel(o_status, o_red, o_green, o_blue, o_alpha, o_has_alpha,
                           o_last_pixel);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [7:0] data,
                             input logic [7:0] pidx, input logic [23:0] pent);
        int gap;
        gap = (tx_choppy && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_data_byte <= data;
        i_palette_index <= pidx;
        i_palette_entry <= pent;
        do begin
            @(posedge i_clk);
        end while (o_in_ready !== 1'b1);
        void'(sb.absorb_input(act, data, pidx, pent));
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_item(ACT_PIXEL, data, 8'($urandom), 24'($urandom));
    endtask

    task automatic send_palette(input logic [7:0] idx, input logic [23:0] word);
        send_item(ACT_PALETTE, 8'($urandom), idx, word);
    endtask

    task automatic send_ctrl(input logic [1:0] act);
        send_item(act, 8'($urandom), 8'($urandom), 24'($urandom));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(addr, val);
    endtask

    // Registers change only once the decoder has gone quiet.
    task automatic set_image(input logic [15:0] typ, input logic [15:0] dep,
                             input logic [15:0] w, input logic [15:0] h);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_write(REG_IMAGE_TYPE, typ);
        cfg_write(REG_PIXEL_DEPTH, dep);
        cfg_write(REG_IMAGE_WIDTH, w);
        cfg_write(REG_IMAGE_HEIGHT, h);
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_ADDR_W'(REG_IMAGE_HEIGHT + 1 + $urandom_range(0, 11)),
                      16'($urandom));
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_image_phase(input bit drain_midway);
        logic [7:0]  typ;
        logic [7:0]  dep;
        logic [7:0]  hi_t;
        logic [7:0]  hi_d;
        logic [15:0] w;
        logic [15:0] h;
        logic [31:0] total;
        bit          good;
        int          bpp;
        int          nbytes;
        int          roll;
        good = 1'b1;
        bpp = 1;
        dep = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
            typ = TYPE_COLORMAP;
        end else if (roll < 85) begin
            typ = TYPE_TRUECOLOR;
            case ($urandom_range(0, 2))
                0: begin dep = DEPTH_16; bpp = 2; end
                1: begin dep = DEPTH_24; bpp = 3; end
                default: begin dep = DEPTH_32; bpp = 4; end
            endcase
        end else if (roll < 90) begin
            typ = TYPE_NO_DATA;
            good = 1'b0;
        end else if (roll < 95) begin
            typ = 8'($urandom_range(TYPE_TRUECOLOR + 1, 255));
            good = 1'b0;
        end else begin
            typ = TYPE_TRUECOLOR;
            while (dep == DEPTH_16 || dep == DEPTH_24 || dep == DEPTH_32)
                dep = 8'($urandom);
            good = 1'b0;
        end
        hi_t = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd0;
        hi_d = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd0;
        if ($urandom_range(0, 9) == 0) begin
            w = pick_extreme();
            h = pick_extreme();
        end else begin
            w = 16'($urandom_range(1, 6));
            h = 16'($urandom_range(1, 4));
        end
        total = 32'(w) * 32'(h);
        if (good && total > 0 && total <= 24)
            nbytes = total * bpp + (($urandom_range(0, 4) == 0) ? 1 : 0);
        else
            nbytes = $urandom_range(3, 40);

        tx_choppy = ($urandom_range(0, 3) != 0);
        rx_choppy = ($urandom_range(0, 3) != 0);
        set_image({hi_t, typ}, {hi_d, dep}, w, h);
        if ($urandom_range(0, 4) != 0)
            send_ctrl(ACT_RESTART);
        for (int k = 0; k < nbytes; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                send_palette(8'($urandom), 24'($urandom));
            else if (roll < 6)
                send_ctrl(ACT_UNUSED);
            else if (roll < 7)
                send_ctrl(ACT_RESTART);
            if (drain_midway && k == nbytes / 2)
                wait_drained();
            send_byte(8'($urandom));
        end
    endtask

    initial begin
        int base;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the whole palette so that no lookup ever hits an unwritten entry.
        for (int i = 0; i < PALETTE_SIZE; i++)
            send_palette(8'(i), (i == 0) ? 24'h000000 :
                         (i == PALETTE_SIZE - 1) ? 24'hFFFFFF : 24'($urandom));

        set_image(TYPE_COLORMAP, DEPTH_16, 16'd2, 16'd1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);

        set_image(TYPE_TRUECOLOR, DEPTH_16, 16'd2, 16'd1);
        send_ctrl(ACT_RESTART);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'h80);

        // A restart in the middle of a pixel drops the bytes already collected.
        set_image(TYPE_TRUECOLOR, DEPTH_24, 16'd1, 16'd1);
        send_ctrl(ACT_RESTART);
        send_byte(8'h00);
        send_byte(8'h80);
        send_ctrl(ACT_RESTART);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'hFF);

        // Dropping the depth while three bytes are held completes the pixel early.
        set_image(TYPE_TRUECOLOR, DEPTH_32, 16'hFFFF, 16'hFFFF);
        send_ctrl(ACT_RESTART);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        send_byte(8'h04);
        send_byte(8'h10);
        send_byte(8'h20);
        send_byte(8'h30);
        set_image(TYPE_TRUECOLOR, DEPTH_16, 16'hFFFF, 16'hFFFF);
        send_byte(8'hC3);

        set_image(TYPE_NO_DATA, 16'd0, 16'd0, 16'd0);
        send_ctrl(ACT_RESTART);
        send_byte(8'hA5);
        send_byte(8'h5A);

        set_image(TYPE_TRUECOLOR, 16'd8, 16'd4, 16'd4);
        send_ctrl(ACT_RESTART);
        send_byte(8'h11);

        set_image(16'h00FF, DEPTH_24, 16'd4, 16'd4);
        send_ctrl(ACT_RESTART);
        send_byte(8'h22);
        send_ctrl(ACT_UNUSED);

        set_image(TYPE_COLORMAP, 16'd0, 16'd0, 16'd5);
        send_ctrl(ACT_RESTART);
        send_byte(8'h33);

        base = items_sent;
        random_image_phase(1'b1);
        while (items_sent - base < RANDOM_ITEMS)
            random_image_phase(1'b0);

        wait_drained();
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d transactions over %0d image settings, all depths and modes.",
                 items_sent, settings_used);
        $display("Checked %0d pixels (%0d image ends) and %0d error reports.",
                 sb.pixels_seen, sb.ends_seen, sb.errors_seen);
        if (sb.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
